// ===== src/ifa_pkg.sv =====
// ifa_pkg: shared types and constants for the integer-to-ASCII formatter.
// Holds character codes, mode codes, and the controller/datapath structs.
// No dependencies.
package ifa_pkg;

  localparam int DATA_W     = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(DATA_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  localparam logic [1:0] MODE_SIGNED   = 2'd0;
  localparam logic [1:0] MODE_UNSIGNED = 2'd1;
  localparam logic [1:0] MODE_HEX      = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'

  // output character source
  localparam logic [1:0] SEL_DIGIT = 2'd0;
  localparam logic [1:0] SEL_ZERO  = 2'd1;
  localparam logic [1:0] SEL_X     = 2'd2;
  localparam logic [1:0] SEL_MINUS = 2'd3;

  typedef struct packed {
    logic       load;
    logic       conv_step;
    logic       dig_step;
    logic       out_load;
    logic [1:0] ch_sel;
    logic       out_last;
  } ifa_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic dig_done;
    logic dig_show;
    logic out_free;
    logic neg;
    logic hex;
  } ifa_sts_t;

endpackage

// ===== src/ifa_datapath.sv =====
// ifa_datapath: double-dabble converter, digit scanner and output register.
// Depends on ifa_pkg; driven by ifa_ctrl through ifa_cmd_t.
module ifa_datapath
  import ifa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ifa_cmd_t              cmd,
  output ifa_sts_t              sts,
  input  logic [1:0]            in_mode,
  input  logic [DATA_W-1:0]     in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char_out,
  output logic                  out_last
);

  logic [DATA_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                 started_r, started_nxt;
  logic                 neg_r, neg_nxt;
  logic                 hex_r, hex_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic [3:0]           top_dig;
  logic                 in_neg;
  logic [7:0]           dig_char;

  assign in_neg  = (in_mode == MODE_SIGNED) && in_value[DATA_W-1];
  assign top_dig = bcd_r[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    if (top_dig < 4'd10) begin
      dig_char = CH_ZERO + {4'd0, top_dig};
    end else begin
      dig_char = CH_A + {4'd0, top_dig - 4'd10};
    end
  end

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    started_nxt = started_r;
    neg_nxt     = neg_r;
    hex_nxt     = hex_r;
    if (cmd.load) begin
      neg_nxt     = in_neg;
      hex_nxt     = in_mode[1];
      bin_nxt     = in_neg ? (~in_value + {{(DATA_W-1){1'b0}}, 1'b1}) : in_value;
      bcd_nxt     = in_mode[1] ? {{(BCD_W-DATA_W){1'b0}}, in_value} : '0;
      bit_cnt_nxt = '0;
      dig_cnt_nxt = '0;
      started_nxt = 1'b0;
    end else if (cmd.conv_step) begin
      bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[DATA_W-1]};
      bin_nxt     = {bin_r[DATA_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end else if (cmd.dig_step) begin
      bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
      dig_cnt_nxt = dig_cnt_r + 1'b1;
      started_nxt = started_r || (top_dig != 4'd0);
    end
  end

  // output register: hold while the receiver stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      last_nxt      = cmd.out_last;
      unique case (cmd.ch_sel)
        SEL_DIGIT: char_nxt = dig_char;
        SEL_ZERO:  char_nxt = CH_ZERO;
        SEL_X:     char_nxt = CH_X;
        SEL_MINUS: char_nxt = CH_MINUS;
        default:   char_nxt = dig_char;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
      started_r   <= 1'b0;
      neg_r       <= 1'b0;
      hex_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      started_r   <= started_nxt;
      neg_r       <= neg_nxt;
      hex_r       <= hex_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign sts.conv_done = (bit_cnt_r == BIT_CNT_W'(DATA_W - 1));
  assign sts.dig_done  = (dig_cnt_r == DIG_CNT_W'(NUM_DIGITS - 1));
  assign sts.dig_show  = started_r || (top_dig != 4'd0) || sts.dig_done;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.neg       = neg_r;
  assign sts.hex       = hex_r;

  assign out_valid    = out_valid_r;
  assign out_char_out = char_r;
  assign out_last     = last_r;

endmodule

// ===== src/ifa_ctrl.sv =====
// ifa_ctrl: sequencing state machine of the formatter.
// Depends on ifa_pkg; commands ifa_datapath.
module ifa_ctrl
  import ifa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  ifa_sts_t   sts,
  output ifa_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_PFX0  = 3'd2;
  localparam logic [2:0] S_PFX1  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode[1] ? S_PFX0 : S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_nxt = sts.neg ? S_PFX0 : S_DIGIT;
        end
      end
      S_PFX0: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ch_sel   = sts.hex ? SEL_ZERO : SEL_MINUS;
          state_nxt    = sts.hex ? S_PFX1 : S_DIGIT;
        end
      end
      S_PFX1: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ch_sel   = SEL_X;
          state_nxt    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        // drop leading zeros, emit the rest
        if (sts.out_free) begin
          cmd.dig_step = 1'b1;
          cmd.out_load = sts.dig_show;
          cmd.ch_sel   = SEL_DIGIT;
          cmd.out_last = sts.dig_done;
          if (sts.dig_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/int_to_ascii_formatter_unit.sv =====
// int_to_ascii_formatter_unit: top level of the integer-to-ASCII formatter.
// Depends on ifa_pkg, ifa_ctrl and ifa_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one beat of in_mode and in_value.
//   in_mode 0 prints in_value as signed decimal ('-' then magnitude),
//   1 as unsigned decimal, 2 (and 3) as "0x" plus lower-case hex digits.
//   Output channel (out_valid/out_ready) returns one character per beat,
//   most significant digit first, with out_last high on the final one.
//   Leading zeros are dropped; zero prints as a single '0'.
// Sequence and rate:
//   Decimal modes run a shift-and-add-3 pass over all 64 input bits first,
//   then scan all 20 digit positions. Hex mode skips the conversion and
//   goes straight to the "0x" prefix and the scan. The digit scan sets the
//   pace after conversion, one position per cycle while the output register
//   is free, including the dropped leading zeros.
//   in_ready is high only while the controller is idle; the next number is
//   taken while the last character of the previous one still waits.
// Reset: synchronous, active low; the controller returns to idle and the
//   output register empties.
// Stalls: a held out_ready freezes the digit scan; the waiting character
//   and its last flag stay unchanged until taken.
module int_to_ascii_formatter_unit
  import ifa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char_out,
  output logic              out_last
);

  ifa_cmd_t cmd;
  ifa_sts_t sts;

  // sequencing: idle, convert, prefix characters, digit scan
  ifa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // conversion registers and the output beat register
  ifa_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

endmodule

// ===== src/ifa_checker.sv =====
// ifa_checker: port-level assertions for int_to_ascii_formatter_unit.
// Depends on ifa_pkg; attached to the top level by the bind below.
module ifa_checker
  import ifa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_char_out,
  input logic              out_last
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_last))
    else $error("output beat changed while stalled");

  // block is busy right after taking a number
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // only digits, hex letters, sign and prefix leave the block
  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_out >= 8'h30 && out_char_out <= 8'h39) ||
                   (out_char_out >= 8'h61 && out_char_out <= 8'h66) ||
                   out_char_out == CH_MINUS || out_char_out == CH_X))
    else $error("illegal output character");

  // sign and prefix never end a number
  a_no_last_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_out == CH_MINUS || out_char_out == CH_X) |-> !out_last)
    else $error("last flag on sign or prefix");

endmodule

bind int_to_ascii_formatter_unit ifa_checker u_ifa_checker (.*);

// ===== sim/tb.sv =====
// tb: self-checking testbench for int_to_ascii_formatter_unit.
// Drives numbers in all modes and predicts the ASCII text that each one formats to.
// Depends on ifa_pkg and the formatter RTL.
module tb;
  import ifa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Stop the run when this many cycles in a row pass with no beat on either channel.
  // The worst legal gap is the long receiver hold-off plus one decimal conversion.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 120;
  localparam int ERR_SHOWN      = 10;

  typedef struct {
    logic [1:0]        mode;
    logic [DATA_W-1:0] value;
  } num_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_mode = MODE_SIGNED;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_char_out;
  logic              out_last;

  num_req_t   num_pending[$];   // numbers waiting to be offered
  text_beat_t text_expected[$]; // characters still owed by the block
  int         sender_idle_pct = 0;
  int         recv_stall_pct  = 0;
  logic       hold_on = 1'b0;
  int         err_cnt = 0;
  int         quiet_cycles = 0;

  int_to_ascii_formatter_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char_out(out_char_out),
    .out_last    (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset low at the start, then release it for good.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Work out the text of one number and queue it, most significant character first.
  // The top mode bit selects hex, so the unused mode code formats as hex too.
  function automatic void predict_text(input logic [1:0] mode, input logic [DATA_W-1:0] value);
    logic [7:0]        text[$];
    logic [7:0]        digits[$];
    logic [DATA_W-1:0] mag;
    logic [3:0]        nib;
    text_beat_t        beat;
    mag = value;
    if (mode[1]) begin
      text.push_back(CH_ZERO);
      text.push_back(CH_X);
    end else if (mode == MODE_SIGNED && value[DATA_W-1]) begin
      // print the magnitude after the sign; the most negative value negates to itself,
      // which read unsigned is the right magnitude
      text.push_back(CH_MINUS);
      mag = -value;
    end
    // peel digits off the low end; the do-while yields a lone '0' for zero
    do begin
      if (mode[1]) begin
        nib = mag[3:0];
        digits.push_front(nib < 4'd10 ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10);
        mag = mag >> 4;
      end else begin
        digits.push_front(CH_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end
    end while (mag != 0);
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      beat.ch   = text[i];
      beat.last = (i == text.size() - 1);
      text_expected.push_back(beat);
    end
  endfunction

  // Pick a value: full random, small, random length, small negative, or near a
  // power of ten so the digit count sits on its boundaries.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] p;
    v = {$urandom, $urandom};
    p = 1;
    case ($urandom_range(0, 4))
      0: ;
      1: v = DATA_W'($urandom_range(0, 1000));
      2: v = v >> $urandom_range(0, DATA_W - 1);
      3: v = -DATA_W'($urandom_range(1, 100000));
      default: begin
        repeat ($urandom_range(0, 19)) p = p * 10;
        v = p - DATA_W'($urandom_range(0, 1));
      end
    endcase
    return v;
  endfunction

  function automatic void queue_num(input logic [1:0] mode, input logic [DATA_W-1:0] value);
    num_req_t r;
    r.mode  = mode;
    r.value = value;
    num_pending.push_back(r);
  endfunction

  // Driver: offer the next number once the current beat is taken (or none is up).
  // Idle only between beats, never by dropping a valid that is already up.
  always @(posedge clk) begin
    num_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (num_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        r = num_pending.pop_front();
        in_mode  <= r.mode;
        in_value <= r.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and stall throughout while the long hold-off runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each input beat, check each output beat against the
  // oldest expectation, and watch for a stuck block.
  always @(posedge clk) begin
    text_beat_t want;
    logic       moved;
    moved = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      predict_text(in_mode, in_value);
      moved = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      moved = 1'b1;
      if (text_expected.size() == 0) begin
        if (err_cnt < ERR_SHOWN)
          $display("unexpected beat: char 0x%02h last %0b", out_char_out, out_last);
        err_cnt++;
      end else begin
        want = text_expected.pop_front();
        if (out_char_out !== want.ch || out_last !== want.last) begin
          if (err_cnt < ERR_SHOWN)
            $display("mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     want.ch, want.last, out_char_out, out_last);
          err_cnt++;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d characters outstanding",
               WATCHDOG_LIMIT, text_expected.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus. All updates land on the falling edge so the clocked blocks
  // never race with them.
  initial begin
    logic [1:0] mode;
    @(posedge rst_n);
    @(negedge clk);

    // Directed numbers: sign and width extremes, digit-count boundaries, both hex
    // codes, zero in every mode and the most negative signed value.
    queue_num(MODE_SIGNED, 64'd0);
    queue_num(MODE_SIGNED, 64'd9);
    queue_num(MODE_SIGNED, 64'd10);
    queue_num(MODE_SIGNED, '1);
    queue_num(MODE_SIGNED, -64'd10);
    queue_num(MODE_SIGNED, 64'h7fff_ffff_ffff_ffff);
    queue_num(MODE_SIGNED, 64'h8000_0000_0000_0000);
    queue_num(MODE_SIGNED, 64'h8000_0000_0000_0001);
    queue_num(MODE_UNSIGNED, 64'd0);
    queue_num(MODE_UNSIGNED, '1);
    queue_num(MODE_UNSIGNED, 64'd10000000000000000000);
    queue_num(MODE_UNSIGNED, 64'd9999999999999999999);
    queue_num(MODE_UNSIGNED, 64'h8000_0000_0000_0000);
    queue_num(MODE_HEX, 64'd0);
    queue_num(MODE_HEX, '1);
    queue_num(MODE_HEX, 64'hf);
    queue_num(MODE_HEX, 64'h10);
    queue_num(MODE_HEX, 64'h0123_4567_89ab_cdef);
    queue_num(2'd3, 64'd0);
    queue_num(2'd3, 64'hdead_beef);
    queue_num(2'd3, '1);
    while (num_pending.size() != 0) @(negedge clk);

    // Squeeze: hold the receiver off for a long stretch while numbers keep coming,
    // so the output backs up and the block stops taking input.
    fork
      begin
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
      end
    join_none
    repeat (40) queue_num(2'($urandom_range(0, 3)), pick_value());
    while (num_pending.size() != 0) @(negedge clk);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 58 : (ph == 3) ? 29 : 0;
      recv_stall_pct  = (ph == 2) ? 58 : (ph == 3) ? 29 : 0;
      repeat (93) begin
        mode = 2'($urandom_range(0, 3));
        queue_num(mode, pick_value());
      end
      while (num_pending.size() != 0) @(negedge clk);
    end

    // Drain: wait for every owed character, then linger to catch strays.
    while (in_valid || text_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (text_expected.size() != 0) begin
      $display("%0d expected characters never arrived", text_expected.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== int_to_ascii_formatter_unit.f =====
src/ifa_pkg.sv
src/ifa_datapath.sv
src/ifa_ctrl.sv
src/int_to_ascii_formatter_unit.sv
src/ifa_checker.sv
sim/tb.sv
